// ----- src/pgs_pkg.sv -----
`default_nettype none

package pgs_pkg;

   // Fixed field widths of the interface.
   localparam int DRAW_W     = 14;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_W      = 32;
   localparam int CSR_ADDR_W = 3;

   // Fixed-point formats of the internal arithmetic.
   localparam int LOG_FRAC   = 24;
   localparam int SCALE_FRAC = 12;
   localparam int MANT_W     = 31;

   // Natural log of two in Q0.32.
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   localparam logic [SAMPLE_W-1:0] SCALE_RESET = 16'd4096;
   localparam logic [SAMPLE_W-1:0] MEAN_RESET  = 16'd0;

   // Register map, indexed by the word address.
   typedef enum logic {
      REG_MEAN  = 1'b0,
      REG_SCALE = 1'b1
   } reg_index_type;

   // Control that travels with each item down the pipeline.
   typedef struct packed {
      logic vld;
      logic neg;
   } tag_type;

   // Base-2 log with LOG_FRAC fraction bits, evaluated at elaboration for constants.
   function automatic longint unsigned log2_fixed(input longint unsigned v);
      longint unsigned m;
      longint unsigned f;
      int              e;
      e = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) e = i;
      end
      if (e > MANT_W - 1) m = v >> (e - (MANT_W - 1));
      else                m = v << ((MANT_W - 1) - e);
      f = 0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         m = (m * m) >> (MANT_W - 1);
         f = f << 1;
         if (m >= (64'd1 << MANT_W)) begin
            m = m >> 1;
            f = f | 64'd1;
         end
      end
      return (longint'(e) << LOG_FRAC) | f;
   endfunction

endpackage

`default_nettype wire

// ----- src/pgs_front.sv -----
`default_nettype none

module pgs_front #(
   parameter int DRAW_MODULUS = 10000,
   localparam int NW  = $clog2(DRAW_MODULUS + 1),
   localparam int SQW = 2 * NW,
   localparam int SW  = SQW + 1,
   localparam int EW  = $clog2(SW)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [pgs_pkg::DRAW_W-1:0]  draw_a,
   input  logic [pgs_pkg::DRAW_W-1:0]  draw_b,
   output pgs_pkg::tag_type            tag_o,
   output logic [SQW-1:0]              a1sq_o,
   output logic [SW-1:0]               s_o,
   output logic [EW-1:0]               e_o,
   output logic [pgs_pkg::MANT_W-1:0]  m_o
);
   import pgs_pkg::*;

   localparam logic [31:0]     DM32 = 32'(DRAW_MODULUS);
   localparam longint unsigned MM   = longint'(DRAW_MODULUS) * longint'(DRAW_MODULUS);

   tag_type             tag1_ff, tag1_in, tag2_ff, tag3_ff, tag3_in, tag4_ff;
   logic [NW-1:0]       a1_ff, a1_in, a2_ff, a2_in;
   logic [SQW-1:0]      sq1_ff, sq2_ff, a1sq3_ff, a1sq4_ff;
   logic [SW-1:0]       s3_ff, s3_in, s4_ff;
   logic [EW-1:0]       e4_ff, e4_in;
   logic [MANT_W-1:0]   m4_ff, m4_in;
   logic [31:0]         twoa, twob;
   logic [SW+MANT_W-1:0] win;

   // Map each draw to |2d - M| and note the sign of the first one.
   always_comb begin
      twoa = 32'({draw_a, 1'b0});
      twob = 32'({draw_b, 1'b0});
      tag1_in.vld = load && (32'(draw_a) < DM32) && (32'(draw_b) < DM32);
      tag1_in.neg = twoa < DM32;
      a1_in = (twoa >= DM32) ? NW'(twoa - DM32) : NW'(DM32 - twoa);
      a2_in = (twob >= DM32) ? NW'(twob - DM32) : NW'(DM32 - twob);
   end

   // Sum of squares and rejection of pairs outside the open unit disk or at its center.
   always_comb begin
      s3_in = SW'(sq1_ff) + SW'(sq2_ff);
      tag3_in.vld = tag2_ff.vld && (s3_in != '0) && (64'(s3_in) < MM);
      tag3_in.neg = tag2_ff.neg;
   end

   // Leading-one search and normalization of the sum to Q1.30.
   always_comb begin
      e4_in = '0;
      for (int i = 0; i < SW; i++) begin
         if (s3_ff[i]) e4_in = EW'(i);
      end
      win   = {s3_ff, {MANT_W{1'b0}}};
      m4_in = MANT_W'(win >> (int'(e4_in) + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag3_in;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      sq1_ff   <= SQW'(a1_ff * a1_ff);
      sq2_ff   <= SQW'(a2_ff * a2_ff);
      a1sq3_ff <= sq1_ff;
      s3_ff    <= s3_in;
      a1sq4_ff <= a1sq3_ff;
      s4_ff    <= s3_ff;
      e4_ff    <= e4_in;
      m4_ff    <= m4_in;
   end

   assign tag_o  = tag4_ff;
   assign a1sq_o = a1sq4_ff;
   assign s_o    = s4_ff;
   assign e_o    = e4_ff;
   assign m_o    = m4_ff;

   a_abs_range: assert property (@(posedge clock) disable iff (reset)
      tag1_ff.vld |-> (32'(a1_ff) <= DM32 && 32'(a2_ff) <= DM32))
      else $error("mapped draw exceeds the modulus");

   a_disk: assert property (@(posedge clock) disable iff (reset)
      tag3_ff.vld |-> (s3_ff != '0 && 64'(s3_ff) < MM))
      else $error("item outside the unit disk kept");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      !tag1_ff.vld |=> !tag2_ff.vld)
      else $error("rejected item revived");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      tag4_ff.vld |-> m4_ff[MANT_W-1])
      else $error("mantissa not normalized");

endmodule

`default_nettype wire

// ----- src/pgs_log.sv -----
`default_nettype none

module pgs_log #(
   parameter int DRAW_MODULUS = 10000,
   localparam int NW  = $clog2(DRAW_MODULUS + 1),
   localparam int SQW = 2 * NW,
   localparam int SW  = SQW + 1,
   localparam int EW  = $clog2(SW),
   localparam int LW  = EW + pgs_pkg::LOG_FRAC
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pgs_pkg::tag_type            tag_i,
   input  logic [SQW-1:0]              a1sq_i,
   input  logic [SW-1:0]               s_i,
   input  logic [EW-1:0]               e_i,
   input  logic [pgs_pkg::MANT_W-1:0]  m_i,
   output pgs_pkg::tag_type            tag_o,
   output logic [SQW-1:0]              a1sq_o,
   output logic [SW-1:0]               s_o,
   output logic [LW-1:0]               lg_o
);
   import pgs_pkg::*;

   localparam int N = LOG_FRAC;

   tag_type             tag_ff  [N];
   logic [SQW-1:0]      a1sq_ff [N];
   logic [SW-1:0]       s_ff    [N];
   logic [EW-1:0]       e_ff    [N];
   logic [MANT_W-1:0]   m_ff    [N];
   logic [MANT_W-1:0]   m_in    [N];
   logic [LOG_FRAC-1:0] f_ff    [N];
   logic [LOG_FRAC-1:0] f_in    [N];

   // One fraction bit per stage: square the mantissa, halve it when it reaches 2.0.
   always_comb begin
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     hi;
      logic [MANT_W-1:0]   sm;
      logic [LOG_FRAC-1:0] sf;
      for (int k = 0; k < N; k++) begin
         sm = (k == 0) ? m_i : m_ff[(k == 0) ? 0 : k - 1];
         sf = (k == 0) ? '0  : f_ff[(k == 0) ? 0 : k - 1];
         sq = sm * sm;
         hi = sq[2*MANT_W-1:MANT_W-1];
         if (hi[MANT_W]) begin
            m_in[k] = hi[MANT_W:1];
            f_in[k] = {sf[LOG_FRAC-2:0], 1'b1};
         end else begin
            m_in[k] = hi[MANT_W-1:0];
            f_in[k] = {sf[LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) tag_ff[k] <= '0;
      end else begin
         for (int k = 0; k < N; k++) tag_ff[k] <= (k == 0) ? tag_i : tag_ff[(k == 0) ? 0 : k - 1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         m_ff[k] <= m_in[k];
         f_ff[k] <= f_in[k];
         if (k == 0) begin
            a1sq_ff[k] <= a1sq_i;
            s_ff[k]    <= s_i;
            e_ff[k]    <= e_i;
         end else begin
            a1sq_ff[k] <= a1sq_ff[k-1];
            s_ff[k]    <= s_ff[k-1];
            e_ff[k]    <= e_ff[k-1];
         end
      end
   end

   assign tag_o  = tag_ff[N-1];
   assign a1sq_o = a1sq_ff[N-1];
   assign s_o    = s_ff[N-1];
   assign lg_o   = {e_ff[N-1], f_ff[N-1]};

endmodule

`default_nettype wire

// ----- src/pgs_quot.sv -----
`default_nettype none

module pgs_quot #(
   parameter int DRAW_MODULUS     = 10000,
   parameter int SAMPLE_FRAC_BITS = 12,
   localparam int NW  = $clog2(DRAW_MODULUS + 1),
   localparam int SQW = 2 * NW,
   localparam int SW  = SQW + 1,
   localparam int EW  = $clog2(SW),
   localparam int LW  = EW + pgs_pkg::LOG_FRAC,
   localparam int TW  = LW + 1,
   localparam int SH  = (2 * SAMPLE_FRAC_BITS > pgs_pkg::LOG_FRAC) ?
                        2 * SAMPLE_FRAC_BITS - pgs_pkg::LOG_FRAC : 0,
   localparam int SHR = (2 * SAMPLE_FRAC_BITS < pgs_pkg::LOG_FRAC) ?
                        pgs_pkg::LOG_FRAC - 2 * SAMPLE_FRAC_BITS : 0,
   localparam int QDW = TW + SH,
   localparam int QW  = QDW - SHR
) (
   input  logic               clock,
   input  logic               reset,
   input  pgs_pkg::tag_type   tag_i,
   input  logic [SQW-1:0]     a1sq_i,
   input  logic [SW-1:0]      s_i,
   input  logic [LW-1:0]      lg_i,
   output pgs_pkg::tag_type   tag_o,
   output logic [QW-1:0]      q_o
);
   import pgs_pkg::*;

   localparam longint unsigned MM   = longint'(DRAW_MODULUS) * longint'(DRAW_MODULUS);
   localparam logic [LW-1:0]   LGMM = LW'(log2_fixed(MM));
   localparam int TLO = TW / 2;
   localparam int THI = TW - TLO;
   localparam int PW  = SQW + TW;

   tag_type          tl_ff, tt_ff, tp1_ff, tp2_ff, tp3_ff;
   logic [LW-1:0]    l_ff, l_in;
   logic [TW-1:0]    t_ff;
   logic [SQW-1:0]   a1sq_l_ff, a1sq_t_ff, a1sq_p1_ff;
   logic [SW-1:0]    s_l_ff, s_t_ff, s_p1_ff, s_p2_ff, s_p3_ff;
   logic [THI-1:0]   thi_ff;
   logic [SQW+TLO-1:0] plo_ff, plo2_ff;
   logic [SQW+THI-1:0] phi_ff;
   logic [PW-1:0]    p_ff;
   logic [LW+31:0]   tprod;

   tag_type          dtag_ff [QDW];
   logic [SW-1:0]    ds_ff   [QDW];
   logic [SW-1:0]    dr_ff   [QDW];
   logic [SW-1:0]    dr_in   [QDW];
   logic [QDW-1:0]   dlow_ff [QDW];
   logic [QDW-1:0]   dlow_in [QDW];
   logic [QDW-1:0]   dq_ff   [QDW];
   logic [QDW-1:0]   dq_in   [QDW];

   // -2 ln w in Q.24 from the log difference, clamped at zero.
   assign l_in  = (lg_i > LGMM) ? '0 : LGMM - lg_i;
   assign tprod = l_ff * LN2_Q32;

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff  <= '0;
         tt_ff  <= '0;
         tp1_ff <= '0;
         tp2_ff <= '0;
         tp3_ff <= '0;
      end else begin
         tl_ff  <= tag_i;
         tt_ff  <= tl_ff;
         tp1_ff <= tt_ff;
         tp2_ff <= tp1_ff;
         tp3_ff <= tp2_ff;
      end
   end

   // Numerator x1^2 * T in partial products over two stages, summed in a third.
   always_ff @(posedge clock) begin
      l_ff       <= l_in;
      a1sq_l_ff  <= a1sq_i;
      s_l_ff     <= s_i;
      t_ff       <= tprod[LW+31:31];
      a1sq_t_ff  <= a1sq_l_ff;
      s_t_ff     <= s_l_ff;
      plo_ff     <= a1sq_t_ff * t_ff[TLO-1:0];
      thi_ff     <= t_ff[TW-1:TLO];
      a1sq_p1_ff <= a1sq_t_ff;
      s_p1_ff    <= s_t_ff;
      phi_ff     <= a1sq_p1_ff * thi_ff;
      plo2_ff    <= plo_ff;
      s_p2_ff    <= s_p1_ff;
      p_ff       <= (PW'(phi_ff) << TLO) + PW'(plo2_ff);
      s_p3_ff    <= s_p2_ff;
   end

   // Restoring division, one quotient bit per stage.
   always_comb begin
      logic [SW-1:0]  sr;
      logic [SW-1:0]  ss;
      logic [QDW-1:0] slow;
      logic [QDW-1:0] sq;
      logic [SW:0]    rt;
      for (int k = 0; k < QDW; k++) begin
         if (k == 0) begin
            sr   = SW'(p_ff[PW-1:TW]);
            ss   = s_p3_ff;
            slow = QDW'(p_ff[TW-1:0]) << SH;
            sq   = '0;
         end else begin
            sr   = dr_ff[(k == 0) ? 0 : k - 1];
            ss   = ds_ff[(k == 0) ? 0 : k - 1];
            slow = dlow_ff[(k == 0) ? 0 : k - 1];
            sq   = dq_ff[(k == 0) ? 0 : k - 1];
         end
         rt = {sr, slow[QDW-1]};
         if (rt >= {1'b0, ss}) begin
            dr_in[k] = SW'(rt - {1'b0, ss});
            dq_in[k] = {sq[QDW-2:0], 1'b1};
         end else begin
            dr_in[k] = SW'(rt);
            dq_in[k] = {sq[QDW-2:0], 1'b0};
         end
         dlow_in[k] = slow << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QDW; k++) dtag_ff[k] <= '0;
      end else begin
         for (int k = 0; k < QDW; k++) dtag_ff[k] <= (k == 0) ? tp3_ff : dtag_ff[(k == 0) ? 0 : k - 1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QDW; k++) begin
         dr_ff[k]   <= dr_in[k];
         dq_ff[k]   <= dq_in[k];
         dlow_ff[k] <= dlow_in[k];
         ds_ff[k]   <= (k == 0) ? s_p3_ff : ds_ff[(k == 0) ? 0 : k - 1];
      end
   end

   assign tag_o = dtag_ff[QDW-1];
   assign q_o   = dq_ff[QDW-1][QDW-1:SHR];

endmodule

`default_nettype wire

// ----- src/pgs_sqrt.sv -----
`default_nettype none

module pgs_sqrt #(
   parameter int QW = 30,
   localparam int QE = QW + (QW % 2),
   localparam int YW = QE / 2
) (
   input  logic               clock,
   input  logic               reset,
   input  pgs_pkg::tag_type   tag_i,
   input  logic [QW-1:0]      q_i,
   output pgs_pkg::tag_type   tag_o,
   output logic [YW-1:0]      y_o
);
   import pgs_pkg::*;

   localparam int RW = YW + 3;

   tag_type         tag_ff  [YW];
   logic [RW-1:0]   rem_ff  [YW];
   logic [RW-1:0]   rem_in  [YW];
   logic [YW-1:0]   root_ff [YW];
   logic [YW-1:0]   root_in [YW];
   logic [QE-1:0]   v_ff    [YW];
   logic [QE-1:0]   v_in    [YW];

   // Digit-by-digit square root: one result bit per stage.
   always_comb begin
      logic [RW-1:0] srem;
      logic [YW-1:0] sroot;
      logic [QE-1:0] sv;
      logic [RW-1:0] remt;
      logic [RW-1:0] trial;
      for (int k = 0; k < YW; k++) begin
         if (k == 0) begin
            srem  = '0;
            sroot = '0;
            sv    = QE'(q_i);
         end else begin
            srem  = rem_ff[(k == 0) ? 0 : k - 1];
            sroot = root_ff[(k == 0) ? 0 : k - 1];
            sv    = v_ff[(k == 0) ? 0 : k - 1];
         end
         remt  = {srem[RW-3:0], sv[QE-1:QE-2]};
         trial = RW'({sroot, 2'b01});
         if (remt >= trial) begin
            rem_in[k]  = remt - trial;
            root_in[k] = {sroot[YW-2:0], 1'b1};
         end else begin
            rem_in[k]  = remt;
            root_in[k] = {sroot[YW-2:0], 1'b0};
         end
         v_in[k] = sv << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < YW; k++) tag_ff[k] <= '0;
      end else begin
         for (int k = 0; k < YW; k++) tag_ff[k] <= (k == 0) ? tag_i : tag_ff[(k == 0) ? 0 : k - 1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < YW; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         v_ff[k]    <= v_in[k];
      end
   end

   assign tag_o = tag_ff[YW-1];
   assign y_o   = root_ff[YW-1];

endmodule

`default_nettype wire

// ----- src/polar_gaussian_sample.sv -----
`default_nettype none

// Marsaglia polar Gaussian sampler, one attempt per pair of draws. The block takes a
// new pair of draws in every clock cycle and busy is always low. A pair inside the
// unit disk, other than its center, gives one sample through 4 front-end stages, 24
// log stages, 5 numerator stages, one division stage per quotient bit, one square-root
// stage per result bit and 3 output stages. A rejected pair gives nothing, and the
// receiver cannot stall: each sample is shown with rsp_strobe for exactly one cycle.
// Write the mean and deviation registers only while no item is in flight.
module polar_gaussian_sample #(
   parameter int DRAW_MODULUS     = 10000,
   parameter int SAMPLE_FRAC_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pgs_pkg::DRAW_W-1:0]     req_draw_a,
   input  logic [pgs_pkg::DRAW_W-1:0]     req_draw_b,
   output logic                           rsp_strobe,
   output logic signed [pgs_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pgs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pgs_pkg::CSR_W-1:0]      pwdata,
   output logic [pgs_pkg::CSR_W-1:0]      prdata,
   output logic                           pready
);
   import pgs_pkg::*;

   localparam int NW  = $clog2(DRAW_MODULUS + 1);
   localparam int SQW = 2 * NW;
   localparam int SW  = SQW + 1;
   localparam int EW  = $clog2(SW);
   localparam int LW  = EW + LOG_FRAC;
   localparam int TW  = LW + 1;
   localparam int SH  = (2 * SAMPLE_FRAC_BITS > LOG_FRAC) ? 2 * SAMPLE_FRAC_BITS - LOG_FRAC : 0;
   localparam int SHR = (2 * SAMPLE_FRAC_BITS < LOG_FRAC) ? LOG_FRAC - 2 * SAMPLE_FRAC_BITS : 0;
   localparam int QW  = TW + SH - SHR;
   localparam int YW  = (QW + (QW % 2)) / 2;
   localparam int PRW = YW + SAMPLE_W;
   localparam int MGW = PRW + 1 - SCALE_FRAC;
   localparam int SUW = MGW + 2;
   localparam logic [PRW:0] ROUND = (PRW + 1)'(1) << (SCALE_FRAC - 1);
   localparam logic signed [SUW-1:0] SAT_HI = SUW'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [SUW-1:0] SAT_LO = -SUW'(1 << (SAMPLE_W - 1));

   logic [SAMPLE_W-1:0] mean_offset_ff, mean_offset_in;
   logic [SAMPLE_W-1:0] deviation_scale_ff, deviation_scale_in;
   logic                csr_write;
   reg_index_type       csr_index;

   tag_type             tag_f, tag_l, tag_q, tag_s;
   logic [SQW-1:0]      a1sq_f, a1sq_l;
   logic [SW-1:0]       s_f, s_l;
   logic [EW-1:0]       e_f;
   logic [MANT_W-1:0]   m_f;
   logic [LW-1:0]       lg_l;
   logic [QW-1:0]       q_q;
   logic [YW-1:0]       y_s;

   tag_type             tag_a_ff, tag_b_ff;
   logic [PRW-1:0]      prod_ff;
   logic [MGW-1:0]      mag_ff;
   logic [PRW:0]        rnd;
   logic signed [SUW-1:0] sm, sum;
   logic                strobe_ff;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // Configuration registers.
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      mean_offset_in     = mean_offset_ff;
      deviation_scale_in = deviation_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MEAN:  mean_offset_in     = pwdata[SAMPLE_W-1:0];
            REG_SCALE: deviation_scale_in = pwdata[SAMPLE_W-1:0];
            default:   mean_offset_in     = mean_offset_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MEAN:  prdata = CSR_W'($signed(mean_offset_ff));
         REG_SCALE: prdata = CSR_W'(deviation_scale_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_offset_ff     <= MEAN_RESET;
         deviation_scale_ff <= SCALE_RESET;
      end else begin
         mean_offset_ff     <= mean_offset_in;
         deviation_scale_ff <= deviation_scale_in;
      end
   end

   // Arithmetic pipeline.
   pgs_front #(.DRAW_MODULUS(DRAW_MODULUS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .load   (start && !busy),
      .draw_a (req_draw_a),
      .draw_b (req_draw_b),
      .tag_o  (tag_f),
      .a1sq_o (a1sq_f),
      .s_o    (s_f),
      .e_o    (e_f),
      .m_o    (m_f)
   );

   pgs_log #(.DRAW_MODULUS(DRAW_MODULUS)) u_log (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (tag_f),
      .a1sq_i (a1sq_f),
      .s_i    (s_f),
      .e_i    (e_f),
      .m_i    (m_f),
      .tag_o  (tag_l),
      .a1sq_o (a1sq_l),
      .s_o    (s_l),
      .lg_o   (lg_l)
   );

   pgs_quot #(
      .DRAW_MODULUS     (DRAW_MODULUS),
      .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
   ) u_quot (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (tag_l),
      .a1sq_i (a1sq_l),
      .s_i    (s_l),
      .lg_i   (lg_l),
      .tag_o  (tag_q),
      .q_o    (q_q)
   );

   pgs_sqrt #(.QW(QW)) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (tag_q),
      .q_i    (q_q),
      .tag_o  (tag_s),
      .y_o    (y_s)
   );

   // Scale by the deviation, round half up, then apply sign and mean with saturation.
   assign rnd = (PRW + 1)'(prod_ff) + ROUND;
   assign sm  = tag_b_ff.neg ? -SUW'($signed({1'b0, mag_ff})) : SUW'($signed({1'b0, mag_ff}));
   assign sum = sm + SUW'($signed(mean_offset_ff));

   always_comb begin
      if (sum > SAT_HI)      sample_in = SAT_HI[SAMPLE_W-1:0];
      else if (sum < SAT_LO) sample_in = SAT_LO[SAMPLE_W-1:0];
      else                   sample_in = sum[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff  <= '0;
         tag_b_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         tag_a_ff  <= tag_s;
         tag_b_ff  <= tag_a_ff;
         strobe_ff <= tag_b_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= y_s * deviation_scale_ff;
      mag_ff    <= rnd[PRW:SCALE_FRAC];
      sample_ff <= sample_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

// ----- tb/polar_gaussian_sample_tb.sv -----
`timescale 1ns / 100ps

module polar_gaussian_sample_tb;
   import pgs_pkg::*;

   localparam int MODULUS     = 10000;
   localparam int LATENCY     = 81;
   localparam int SETTLE      = LATENCY + 20;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic [DRAW_W-1:0] draw_a;
      logic [DRAW_W-1:0] draw_b;
   } draw_pair_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [DRAW_W-1:0]          req_draw_a;
   logic [DRAW_W-1:0]          req_draw_b;
   logic                       rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_W-1:0]      paddr;
   logic [CSR_W-1:0]           pwdata;
   logic [CSR_W-1:0]           prdata;
   logic                       pready;

   // Predictor copy of the two registers.
   logic signed [15:0] model_mean;
   logic [15:0]        model_scale;

   draw_pair_type              pending_pairs[$];
   logic signed [SAMPLE_W-1:0] expected_samples[$];
   int                         mismatch_count;
   int                         gap_left;

   polar_gaussian_sample u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_draw_a (req_draw_a),
      .req_draw_b (req_draw_b),
      .rsp_strobe (rsp_strobe),
      .rsp_sample (rsp_sample),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Base-2 log of v in Q.24: exponent, then one fraction bit per mantissa squaring.
   function automatic longint unsigned log2_q24(input longint unsigned v);
      longint unsigned mant;
      longint unsigned frac;
      int              expo;
      expo = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) expo = i;
      end
      if (expo > 30) mant = v >> (expo - 30);
      else           mant = v << (30 - expo);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            frac = frac | 64'd1;
         end
      end
      return (longint'(expo) << 24) | frac;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Works out the sample for one pair of draws; returns 0 when the pair is rejected.
   function automatic bit predict_sample(input draw_pair_type pair,
                                         output logic signed [15:0] sample);
      longint          n1;
      longint          n2;
      longint unsigned a1;
      longint unsigned a2;
      longint unsigned radius_sq;
      longint unsigned mod_sq;
      longint          log_ratio;
      longint unsigned neg_log;
      longint unsigned num;
      longint unsigned y_sq;
      longint unsigned mag;
      longint          total;
      sample = '0;
      if (pair.draw_a >= MODULUS || pair.draw_b >= MODULUS) return 1'b0;
      n1 = 2 * longint'(pair.draw_a) - MODULUS;
      n2 = 2 * longint'(pair.draw_b) - MODULUS;
      a1 = (n1 < 0) ? -n1 : n1;
      a2 = (n2 < 0) ? -n2 : n2;
      radius_sq = a1 * a1 + a2 * a2;
      mod_sq    = MODULUS * MODULUS;
      if (radius_sq == 0 || radius_sq >= mod_sq) return 1'b0;
      log_ratio = longint'(log2_q24(mod_sq)) - longint'(log2_q24(radius_sq));
      if (log_ratio < 0) log_ratio = 0;
      neg_log = (unsigned'(log_ratio) * 64'hB17217F8) >> 31;
      // Shift of 2F-24 is zero for Q.12 output, so the quotient is a plain floor.
      num  = a1 * a1 * neg_log;
      y_sq = num / radius_sq;
      mag  = (floor_sqrt(y_sq) * model_scale + 2048) >> 12;
      total = ((n1 < 0) ? -longint'(mag) : longint'(mag)) + model_mean;
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      sample = total[15:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // Register write: setup then access cycle, pready is always high.
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MEAN) model_mean = value;
      else                 model_scale = value;
   endtask

   task automatic queue_pair(input int a, input int b);
      draw_pair_type pair;
      pair.draw_a = a[DRAW_W-1:0];
      pair.draw_b = b[DRAW_W-1:0];
      pending_pairs = {pending_pairs, pair};
   endtask

   // Waits for the driver to drain and the pipe to empty, then reports any sample that did not come back.
   task automatic wait_idle();
      while (pending_pairs.size() != 0 || start) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch($sformatf("%0d samples missing", expected_samples.size()));
      expected_samples.delete();
   endtask

   // Mostly in-range pairs, a few out-of-range or wide-bit values.
   task automatic queue_random(input int count);
      int a;
      int b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            a = $urandom_range(0, 16383);
            b = $urandom_range(0, 16383);
         end else begin
            a = $urandom_range(0, MODULUS - 1);
            b = $urandom_range(0, MODULUS - 1);
         end
         queue_pair(a, b);
      end
   endtask

   // Driver: one pair per start, with a random gap after each.
   always @(posedge clock) begin
      draw_pair_type      pair;
      draw_pair_type      taken;
      logic signed [15:0] sample;
      if (reset) begin
         start      <= 1'b0;
         gap_left   <= 0;
         req_draw_a <= '0;
         req_draw_b <= '0;
      end else begin
         if (start && !busy) begin
            taken.draw_a = req_draw_a;
            taken.draw_b = req_draw_b;
            if (predict_sample(taken, sample))
               expected_samples = {expected_samples, sample};
         end
         if (start && busy) begin
            // hold the current item
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_pairs.size() != 0) begin
            pair       = pending_pairs.pop_front();
            start      <= 1'b1;
            req_draw_a <= pair.draw_a;
            req_draw_b <= pair.draw_b;
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobed sample is checked against the oldest prediction.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d", rsp_sample));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want)
               report_mismatch($sformatf("sample %0d, expected %0d", rsp_sample, want));
         end
      end
   end

   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [15:0] means[4];
      logic [15:0] scales[4];
      mismatch_count = 0;
      model_mean     = 16'sd0;
      model_scale    = 16'd4096;
      reset      = 1'b1;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs at reset settings: edges, center, zero x1, rejects.
      queue_pair(5000, 5000);
      queue_pair(5000, 5001);
      queue_pair(5001, 5000);
      queue_pair(4999, 5000);
      queue_pair(0, 0);
      queue_pair(0, 5000);
      queue_pair(1, 5000);
      queue_pair(9999, 5000);
      queue_pair(5000, 9999);
      queue_pair(9999, 9999);
      queue_pair(8535, 8535);
      queue_pair(1465, 8535);
      queue_pair(10000, 5000);
      queue_pair(5000, 10000);
      queue_pair(16383, 16383);
      queue_pair(5000, 9998);
      queue_pair(9998, 5002);
      queue_pair(2, 5000);
      wait_idle();

      // Several register settings, extremes included.
      means  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hF000};
      scales = '{16'hFFFF, 16'h0000, 16'h1000, 16'h0800};
      for (int s = 0; s < 4; s++) begin
         write_reg(REG_MEAN, means[s]);
         write_reg(REG_SCALE, scales[s]);
         queue_pair(5001, 5000);
         queue_pair(1, 5000);
         queue_pair(9999, 5000);
         queue_pair(5000, 5000);
         queue_random(RANDOM_ITEMS / 8);
         wait_idle();
      end
      write_reg(REG_MEAN, 16'($urandom_range(0, 65535)));
      write_reg(REG_SCALE, 16'($urandom_range(0, 65535)));
      queue_random(RANDOM_ITEMS / 4);
      wait_idle();
      write_reg(REG_MEAN, 16'h0000);
      write_reg(REG_SCALE, 16'd4096);
      queue_random(RANDOM_ITEMS / 4);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- polar_gaussian_sample.f -----
src/pgs_pkg.sv
src/pgs_front.sv
src/pgs_log.sv
src/pgs_quot.sv
src/pgs_sqrt.sv
src/polar_gaussian_sample.sv
tb/polar_gaussian_sample_tb.sv
